/* design/lts_pkg.sv */
// Shared types and constants of the loop timing sampler.
`default_nettype none
package lts_pkg;

   localparam int FIFO_DEPTH = 128;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam int OQ_DEPTH   = 4;
   localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

   localparam logic [15:0] PERIOD_RESET = 16'd4;
   localparam logic [15:0] WORK_MAX     = 16'hffff;

   typedef enum logic [1:0] {
      FUNC_IDLE = 2'd0,
      FUNC_WORK = 2'd1,
      FUNC_CMD  = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   localparam logic [7:0] CMD_DUMP   = 8'd1;
   localparam logic [7:0] CMD_RESET  = 8'd2;
   localparam logic [7:0] CMD_PERIOD = 8'd3;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } oq_entry_type;

endpackage
`default_nettype wire

/* design/loop_timing_sampler_top.sv */
// Loop timing sampler: event decode, sample FIFO and response queue.
// Responses reach rsp_ through the request register and the response queue; a FIFO pop response
// also passes through the registered memory read.
// Throughput: one request per cycle unless held; an idle event that pushes a sample or pops an entry
// holds the next request during its second write or its read; requests also hold with over two words queued.
// Reset: synchronous, active high; clears control state, period to 4, tag to 0, FIFO data kept.
`default_nettype none
module loop_timing_sampler_top (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // timer[31:0], link_busy[32], cmd_mode[40:33],
                                    // cmd_value[56:41], zero fill [63:57]
   input  wire  [1:0]  req_tuser,   // func[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // report_word[31:0]
   output logic        rsp_tlast,
   // tag register write
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [7:0]  csr_data
);

   localparam int PW = lts_pkg::PTR_W;
   localparam int CW = lts_pkg::CNT_W;
   localparam int QP = lts_pkg::OQ_PTR_W;
   localparam int QC = lts_pkg::OQ_CNT_W;

   // ---------------- tag register ----------------
   logic [7:0] tag_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= 8'd0;
      end else if (csr_valid) begin
         tag_ff <= csr_data;
      end
   end

   // ---------------- request register ----------------
   logic                 s1_valid_ff;
   lts_pkg::func_type    s1_func_ff;
   logic [31:0]          s1_timer_ff;
   logic                 s1_busy_ff;
   logic [7:0]           s1_mode_ff;
   logic [15:0]          s1_value_ff;
   logic                 s1_fire;

   assign req_tready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_func_ff  <= lts_pkg::func_type'(req_tuser);
         s1_timer_ff <= req_tdata[31:0];
         s1_busy_ff  <= req_tdata[32];
         s1_mode_ff  <= req_tdata[40:33];
         s1_value_ff <= req_tdata[56:41];
      end
   end

   // ---------------- sampler state ----------------
   logic          running_ff, running_in;
   logic          dreq_ff, dreq_in;
   logic          dumping_ff, dumping_in;
   logic          awaiting_ff, awaiting_in;
   logic [15:0]   work_ff, work_in;
   logic [31:0]   idle_ff, idle_in;
   logic [31:0]   first_ff, first_in;
   logic [31:0]   second_ff, second_in;
   logic [15:0]   period_ff, period_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   // second sample word is held in a register for the memory write port
   logic          push2_ff, push2_in;
   logic [PW-1:0] push2_addr_ff, push2_addr_in;
   logic [31:0]   push2_data_ff, push2_data_in;

   // popped entry comes back from the registered memory read
   logic          rd_pend_ff;
   logic [31:0]   rd_data_ff;

   // response queue
   lts_pkg::oq_entry_type oq_ff [lts_pkg::OQ_DEPTH];
   logic [QP-1:0] oq_head_ff, oq_tail_ff;
   logic [QC-1:0] oq_count_ff;

   // memory port controls
   logic          mem_we;
   logic [PW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic          mem_re;

   // enqueue controls
   logic                  enq0, enq1;
   lts_pkg::oq_entry_type enq0_data, enq1_data;

   // hold processing during a memory access of the last request or with over two words queued
   assign s1_fire = s1_valid_ff && !push2_ff && !rd_pend_ff &&
                    (oq_count_ff <= QC'(lts_pkg::OQ_DEPTH - 2));

   // next-state logic for one processed request
   always_comb begin
      logic [31:0]   idle_inc;
      logic [15:0]   work_inc;
      logic [CW-1:0] cnt;
      logic [PW-1:0] wp;
      logic          dump_now;

      running_in    = running_ff;
      dreq_in       = dreq_ff;
      dumping_in    = dumping_ff;
      awaiting_in   = awaiting_ff;
      work_in       = work_ff;
      idle_in       = idle_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      period_in     = period_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      count_in      = count_ff;
      push2_in      = 1'b0;
      push2_addr_in = push2_addr_ff;
      push2_data_in = push2_data_ff;
      mem_we        = push2_ff;
      mem_waddr     = push2_addr_ff;
      mem_wdata     = push2_data_ff;
      mem_re        = 1'b0;
      enq0          = rd_pend_ff;
      enq1          = 1'b0;
      enq0_data     = '{word: {tag_ff, rd_data_ff[23:0]}, last: 1'b1};
      enq1_data     = '{word: {tag_ff, 8'd0, period_ff}, last: 1'b1};

      idle_inc = idle_ff + 32'd1;
      work_inc = (work_ff < lts_pkg::WORK_MAX) ? work_ff + 16'd1 : work_ff;
      cnt      = count_ff;
      wp       = wr_ptr_ff;
      dump_now = dumping_ff;

      if (s1_fire) begin
         case (s1_func_ff)
            lts_pkg::FUNC_IDLE: begin
               idle_in = idle_inc;
               if (work_ff >= period_ff) begin
                  if (dreq_ff) begin
                     dreq_in    = 1'b0;
                     dump_now   = 1'b1;
                     running_in = 1'b0;
                  end
                  dumping_in = dump_now;
                  if (dump_now) begin
                     if (count_ff != '0) begin
                        if (!s1_busy_ff) begin
                           // pop the oldest entry
                           mem_re    = 1'b1;
                           rd_ptr_in = (rd_ptr_ff == PW'(lts_pkg::FIFO_DEPTH - 1)) ?
                                       '0 : rd_ptr_ff + PW'(1);
                           count_in  = count_ff - CW'(1);
                        end
                     end else begin
                        dumping_in = 1'b0;
                        running_in = 1'b1;
                     end
                  end else begin
                     // push idle count now, timer difference next cycle; drop when full
                     if (cnt < CW'(lts_pkg::FIFO_DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_waddr = wp;
                        mem_wdata = idle_inc;
                        wp  = (wp == PW'(lts_pkg::FIFO_DEPTH - 1)) ? '0 : wp + PW'(1);
                        cnt = cnt + CW'(1);
                     end
                     if (cnt < CW'(lts_pkg::FIFO_DEPTH)) begin
                        push2_in      = 1'b1;
                        push2_addr_in = wp;
                        push2_data_in = second_ff - first_ff;
                        wp  = (wp == PW'(lts_pkg::FIFO_DEPTH - 1)) ? '0 : wp + PW'(1);
                        cnt = cnt + CW'(1);
                     end
                     wr_ptr_in   = wp;
                     count_in    = cnt;
                     first_in    = 32'd0;
                     second_in   = 32'd0;
                     awaiting_in = 1'b1;
                     work_in     = 16'd0;
                     idle_in     = 32'd0;
                  end
               end
            end
            lts_pkg::FUNC_WORK: begin
               if (running_ff) begin
                  work_in = work_inc;
                  if (awaiting_ff) begin
                     first_in    = s1_timer_ff;
                     awaiting_in = 1'b0;
                  end else if (work_inc == period_ff) begin
                     second_in = s1_timer_ff;
                  end
               end
            end
            lts_pkg::FUNC_CMD: begin
               unique case (s1_mode_ff)
                  lts_pkg::CMD_DUMP: begin
                     if (!dreq_ff) begin
                        dreq_in   = 1'b1;
                        enq0      = 1'b1;
                        enq1      = 1'b1;
                        enq0_data = '{word: {tag_ff, 24'd0}, last: 1'b0};
                     end
                  end
                  lts_pkg::CMD_RESET: begin
                     running_in  = 1'b1;
                     rd_ptr_in   = '0;
                     wr_ptr_in   = '0;
                     count_in    = '0;
                     dreq_in     = 1'b0;
                     dumping_in  = 1'b0;
                     awaiting_in = 1'b1;
                     work_in     = 16'd0;
                  end
                  lts_pkg::CMD_PERIOD: begin
                     period_in = s1_value_ff;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b1;
         dreq_ff     <= 1'b0;
         dumping_ff  <= 1'b0;
         awaiting_ff <= 1'b1;
         work_ff     <= 16'd0;
         idle_ff     <= 32'd0;
         first_ff    <= 32'd0;
         second_ff   <= 32'd0;
         period_ff   <= lts_pkg::PERIOD_RESET;
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         count_ff    <= '0;
         push2_ff    <= 1'b0;
         rd_pend_ff  <= 1'b0;
      end else begin
         running_ff  <= running_in;
         dreq_ff     <= dreq_in;
         dumping_ff  <= dumping_in;
         awaiting_ff <= awaiting_in;
         work_ff     <= work_in;
         idle_ff     <= idle_in;
         first_ff    <= first_in;
         second_ff   <= second_in;
         period_ff   <= period_in;
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         count_ff    <= count_in;
         push2_ff    <= push2_in;
         rd_pend_ff  <= mem_re;
      end
   end

   always_ff @(posedge clock) begin
      push2_addr_ff <= push2_addr_in;
      push2_data_ff <= push2_data_in;
   end

   // ---------------- sample FIFO storage ----------------
   logic [31:0] fifo_mem [lts_pkg::FIFO_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         fifo_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= fifo_mem[rd_ptr_ff];
      end
   end

   // ---------------- response queue ----------------
   logic deq;
   assign deq        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (oq_count_ff != '0);
   assign rsp_tdata  = oq_ff[oq_head_ff].word;
   assign rsp_tlast  = oq_ff[oq_head_ff].last;

   always_ff @(posedge clock) begin
      if (enq0) begin
         oq_ff[oq_tail_ff] <= enq0_data;
      end
      if (enq1) begin
         oq_ff[oq_tail_ff + QP'(1)] <= enq1_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_head_ff  <= '0;
         oq_tail_ff  <= '0;
         oq_count_ff <= '0;
      end else begin
         // advance tail by the number of words queued, head by one per handshake
         oq_tail_ff  <= oq_tail_ff + QP'(enq0) + QP'(enq1);
         oq_head_ff  <= oq_head_ff + QP'(deq);
         oq_count_ff <= oq_count_ff + QC'(enq0) + QC'(enq1) - QC'(deq);
      end
   end

`ifndef SYNTH
   a_fifo_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(lts_pkg::FIFO_DEPTH))
      else $error("sample FIFO count above depth");

   a_oq_bound : assert property (@(posedge clock) disable iff (reset)
      oq_count_ff <= QC'(lts_pkg::OQ_DEPTH))
      else $error("response queue overflow");

   a_push2_hold : assert property (@(posedge clock) disable iff (reset)
      push2_ff |-> !s1_fire)
      else $error("request processed during second FIFO write");

   a_pop_return : assert property (@(posedge clock) disable iff (reset)
      mem_re |=> rd_pend_ff && !s1_fire)
      else $error("pop result not returned in order");

   a_dump_stops_run : assert property (@(posedge clock) disable iff (reset)
      dumping_ff |-> !running_ff)
      else $error("sampler running while dumping");
`endif

endmodule
`default_nettype wire

/* tb/loop_timing_sampler_top_tb.sv */
// Self-checking testbench of the loop timing sampler: directed and random events, reports checked.
`timescale 1ns / 100ps
module loop_timing_sampler_top_tb;

   // Cycles to let pass after the last expected report before the block counts as idle: a pop answers
   // through the registered memory read, and a sample push holds the block for its second FIFO write.
   localparam int SETTLE_CYCLES = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // timer[31:0], link_busy[32], cmd_mode[40:33],
                                  // cmd_value[56:41], zero fill [63:57]
   logic [1:0]  req_tuser = '0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // report_word[31:0]
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   loop_timing_sampler_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Idle and stall rates, in cycles out of a hundred.
   int unsigned send_idle_pct = 30;
   int unsigned rsp_stall_pct = 57;

   // Sampler state as the testbench tracks it.
   logic [7:0]  tag_reg;
   logic        sampling_on;
   logic        dump_pending;
   logic        dump_active;
   logic        want_start;
   logic [15:0] work_count;
   logic [31:0] idle_count;
   logic [31:0] start_time;
   logic [31:0] stop_time;
   logic [15:0] period_len;
   logic [31:0] sample_store[$];

   // Reports still owed by the block, oldest first.
   lts_pkg::oq_entry_type expected_reports[$];
   lts_pkg::oq_entry_type want_report;

   int unsigned fail_count      = 0;
   int unsigned requests_sent   = 0;
   int unsigned reports_checked = 0;
   int unsigned dump_entries    = 0;
   int unsigned dropped_samples = 0;
   int unsigned saturated_calls = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop, far past the slowest correct run.
   initial begin
      #20_000_000;
      $display("Timed out with %0d reports still expected", expected_reports.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // Stall the report channel at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compare each accepted report with the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            $error("report_word: nothing expected, got %h (last %b)", rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want_report = expected_reports.pop_front();
            reports_checked++;
            if (rsp_tdata !== want_report.word) begin
               $error("report_word: expected %h, got %h", want_report.word, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want_report.last) begin
               $error("last: expected %b, got %b", want_report.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   task automatic owe_report(logic [23:0] payload, logic last);
      expected_reports.push_back('{word: {tag_reg, payload}, last: last});
   endtask

   task automatic store_sample(logic [31:0] sample);
      if (sample_store.size() < lts_pkg::FIFO_DEPTH) begin
         sample_store.push_back(sample);
      end else begin
         dropped_samples++;
      end
   endtask

   // Advance the tracked state by one accepted request and owe its reports.
   task automatic predict_event(lts_pkg::func_type f, logic [31:0] timer, logic busy,
                                logic [7:0] mode, logic [15:0] value);
      logic [31:0] popped;
      case (f)
         lts_pkg::FUNC_IDLE: begin
            idle_count = idle_count + 32'd1;
            if (work_count >= period_len) begin
               if (dump_pending) begin
                  dump_pending = 1'b0;
                  dump_active  = 1'b1;
                  sampling_on  = 1'b0;
                  dump_entries++;
               end
               if (dump_active) begin
                  // pop only while the link is free; an empty FIFO ends the dump
                  if (sample_store.size() != 0) begin
                     if (!busy) begin
                        popped = sample_store.pop_front();
                        owe_report(popped[23:0], 1'b1);
                     end
                  end else begin
                     dump_active = 1'b0;
                     sampling_on = 1'b1;
                  end
               end else begin
                  store_sample(idle_count);
                  store_sample(stop_time - start_time);
                  start_time = '0;
                  stop_time  = '0;
                  want_start = 1'b1;
                  work_count = '0;
                  idle_count = '0;
               end
            end
         end
         lts_pkg::FUNC_WORK: begin
            if (sampling_on) begin
               if (work_count != lts_pkg::WORK_MAX) work_count = work_count + 16'd1;
               else saturated_calls++;
               if (want_start) begin
                  start_time = timer;
                  want_start = 1'b0;
               end else if (work_count == period_len) begin
                  stop_time = timer;
               end
            end
         end
         lts_pkg::FUNC_CMD: begin
            if (mode == lts_pkg::CMD_DUMP) begin
               if (!dump_pending) begin
                  dump_pending = 1'b1;
                  owe_report(24'd0, 1'b0);
                  owe_report({8'd0, period_len}, 1'b1);
               end
            end else if (mode == lts_pkg::CMD_RESET) begin
               sampling_on  = 1'b1;
               sample_store.delete();
               dump_pending = 1'b0;
               dump_active  = 1'b0;
               want_start   = 1'b1;
               work_count   = '0;
            end else if (mode == lts_pkg::CMD_PERIOD) begin
               period_len = value;
            end
         end
         default: ;
      endcase
   endtask

   // Offer one request, after a random gap, and hold it until accepted.
   // Called at a rising edge; returns at the edge that accepted the request.
   task automatic send_event(lts_pkg::func_type f, logic [31:0] timer, logic busy,
                             logic [7:0] mode, logic [15:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {7'd0, value, mode, busy, timer};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      predict_event(f, timer, busy, mode, value);
   endtask

   // Hold off requests until every owed report has come and the block has settled.
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the tag register; only called with the block idle.
   task automatic write_tag(logic [7:0] tag);
      csr_valid <= 1'b1;
      csr_data  <= tag;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tag_reg = tag;
   endtask

   // A dump request with an empty FIFO, a repeated dump request, ignored events, a wrapped timer
   // difference, period zero, a busy link during dump, and the end of dump mode.
   task automatic test_directed_cases();
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_DUMP, 16'd0);
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b1, lts_pkg::CMD_DUMP, 16'd0);
      send_event(lts_pkg::FUNC_IDLE, $urandom, 1'b0, 8'd0, 16'd0);
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_RESET, 16'd0);
      send_event(lts_pkg::FUNC_WORK, 32'hFFFF_FFF0, 1'b0, 8'd0, 16'd0);
      send_event(lts_pkg::FUNC_WORK, 32'h0000_0000, 1'b1, 8'hFF, 16'hFFFF);
      send_event(lts_pkg::FUNC_WORK, 32'hFFFF_FFFF, 1'b0, 8'd0, 16'd0);
      send_event(lts_pkg::FUNC_WORK, 32'h0000_0010, 1'b0, 8'd0, 16'd0);
      send_event(lts_pkg::FUNC_NONE, $urandom, 1'b1, lts_pkg::CMD_DUMP, 16'hFFFF);
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, 8'h00, 16'hFFFF);
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, 8'hFF, 16'd0);
      send_event(lts_pkg::FUNC_IDLE, $urandom, 1'b1, 8'd0, 16'd0);
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_PERIOD, 16'd0);
      send_event(lts_pkg::FUNC_IDLE, $urandom, 1'b0, 8'd0, 16'd0);
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_PERIOD, 16'd2);
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_DUMP, 16'd0);
      send_event(lts_pkg::FUNC_WORK, $urandom, 1'b0, 8'd0, 16'd0);
      send_event(lts_pkg::FUNC_WORK, $urandom, 1'b0, 8'd0, 16'd0);
      // dump mode starts here, but the link is busy: nothing comes out
      send_event(lts_pkg::FUNC_IDLE, $urandom, 1'b1, 8'd0, 16'd0);
      send_event(lts_pkg::FUNC_WORK, $urandom, 1'b0, 8'd0, 16'd0);
      repeat (4) send_event(lts_pkg::FUNC_IDLE, $urandom, 1'b0, 8'd0, 16'd0);
      send_event(lts_pkg::FUNC_IDLE, $urandom, 1'b0, 8'd0, 16'd0);
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_PERIOD, 16'd4);
   endtask

   // Fill the FIFO past its depth with period zero, then dump all of it.
   task automatic test_fifo_overflow();
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_RESET, 16'($urandom));
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_PERIOD, 16'd0);
      repeat (lts_pkg::FIFO_DEPTH / 2 + 2) begin
         send_event(lts_pkg::FUNC_IDLE, $urandom, 1'($urandom), 8'($urandom), 16'($urandom));
      end
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_DUMP, 16'($urandom));
      while (dump_pending || dump_active) begin
         send_event(lts_pkg::FUNC_IDLE, $urandom, ($urandom_range(99) < 25), 8'($urandom),
                    16'($urandom));
      end
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_PERIOD, 16'd4);
   endtask

   // Count work under a long period, sample it with a shorter one that it has passed, and dump it.
   task automatic test_long_period();
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_RESET, 16'($urandom));
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_PERIOD, 16'hFFFF);
      repeat (60) begin
         send_event(lts_pkg::FUNC_WORK, $urandom, 1'($urandom), 8'($urandom), 16'($urandom));
      end
      repeat (3) send_event(lts_pkg::FUNC_IDLE, $urandom, 1'b0, 8'd0, 16'd0);
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_PERIOD, 16'd40);
      send_event(lts_pkg::FUNC_IDLE, $urandom, 1'b0, 8'd0, 16'd0);
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_PERIOD, 16'd0);
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_DUMP, 16'($urandom));
      while (dump_pending || dump_active) begin
         send_event(lts_pkg::FUNC_IDLE, $urandom, ($urandom_range(99) < 25), 8'($urandom),
                    16'($urandom));
      end
      send_event(lts_pkg::FUNC_CMD, $urandom, 1'b0, lts_pkg::CMD_PERIOD, 16'd4);
   endtask

   // Random mix of work, idle and command events with mostly small periods.
   task automatic test_random_traffic(int unsigned count);
      lts_pkg::func_type f;
      logic [31:0] timer;
      logic        busy;
      logic [7:0]  mode;
      logic [15:0] value;
      int unsigned pick;
      int unsigned sub;
      repeat (count) begin
         timer = $urandom;
         busy  = ($urandom_range(99) < 30);
         mode  = 8'($urandom);
         value = 16'($urandom);
         pick  = $urandom_range(99);
         if (pick < 40) begin
            f = lts_pkg::FUNC_WORK;
         end else if (pick < 75) begin
            f = lts_pkg::FUNC_IDLE;
         end else if (pick < 77) begin
            f = lts_pkg::FUNC_NONE;
         end else begin
            f   = lts_pkg::FUNC_CMD;
            sub = $urandom_range(99);
            if (sub < 35) begin
               mode = lts_pkg::CMD_DUMP;
            end else if (sub < 45) begin
               mode = lts_pkg::CMD_RESET;
            end else if (sub < 75) begin
               mode = lts_pkg::CMD_PERIOD;
               // keep the period small most of the time so samples and dumps happen
               if ($urandom_range(9) != 0) value = 16'($urandom_range(6));
            end
         end
         send_event(f, timer, busy, mode, value);
         // now and then hold off until everything owed has come back
         if ($urandom_range(99) == 0) drain_reports();
      end
   endtask

   initial begin
      tag_reg      = 8'd0;
      sampling_on  = 1'b1;
      dump_pending = 1'b0;
      dump_active  = 1'b0;
      want_start   = 1'b1;
      work_count   = '0;
      idle_count   = '0;
      start_time   = '0;
      stop_time    = '0;
      period_len   = lts_pkg::PERIOD_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase one: sender idles 30%, receiver stalls 57%
      write_tag(8'h00);
      test_directed_cases();
      drain_reports();
      write_tag(8'hFF);
      test_fifo_overflow();
      drain_reports();
      write_tag(8'($urandom));
      test_random_traffic(250);
      drain_reports();

      // phase two: rates swapped
      send_idle_pct = 57;
      rsp_stall_pct = 30;
      write_tag(8'hFF);
      test_random_traffic(250);
      drain_reports();

      // phase three: no idling on either side
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_tag(8'h00);
      test_long_period();
      drain_reports();
      write_tag(8'($urandom));
      test_random_traffic(250);
      drain_reports();

      if (expected_reports.size() != 0) begin
         $error("report_word: %0d reports never came", expected_reports.size());
         fail_count++;
      end
      $display("Covered %0d requests under three stall profiles, %0d reports compared.",
               requests_sent, reports_checked);
      $display("Dump mode entered %0d times, %0d samples dropped on full FIFO, %0d saturated.",
               dump_entries, dropped_samples, saturated_calls);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
